FILE: rtl/core/cbd_pkg.sv
// Package for the console CPU bus decoder with sprite DMA.
// Holds the word types, operation codes, phase codes and the RAM write request.
// Depends on nothing; used by cbd_exec and the top level.
package cbd_pkg;

    // Operation codes of an input word.
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // Tick phases of the six-phase counter.
    localparam logic [2:0] PHASE_FETCH = 3'd0;
    localparam logic [2:0] PHASE_STORE = 3'd3;
    localparam logic [2:0] PHASE_LAST  = 3'd5;

    // Decoded addresses.
    localparam logic [15:0] RAM_TOP      = 16'h1FFF;
    localparam logic [15:0] RAM_MIRROR   = 16'h07FF;
    localparam logic [2:0]  PPU_WINDOW   = 3'b001;
    localparam logic [15:0] DMA_PAGE_ADR = 16'h4014;
    localparam logic [14:0] PAD_PAIR     = 15'h200B;

    // Input word.
    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic        read_only;
        logic        cart_claims;
        logic [7:0]  cart_data;
        logic [7:0]  ppu_data;
        logic [7:0]  controller_buttons;
        logic        ppu_nmi;
    } t_in_word;

    // Result word.
    typedef struct packed {
        logic [7:0]  read_data;
        logic        ppu_access;
        logic [2:0]  ppu_register;
        logic        ppu_peek;
        logic        cpu_step;
        logic        oam_write;
        logic [7:0]  oam_address;
        logic [7:0]  oam_data;
        logic        nmi_to_cpu;
        logic [15:0] dma_fetch_address;
    } t_out_word;

    // Work RAM write request from the execute stage.
    typedef struct packed {
        logic        en;
        logic [15:0] addr;
        logic [7:0]  data;
    } t_ram_wr;

endpackage

FILE: rtl/core/cbd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Width and depth are parameters; no package dependency.
module cbd_ram #(
    parameter int WIDTH      = 8,
    parameter int DEPTH_BITS = 11
) (
    input  logic                  i_clk,
    input  logic                  i_wr_en,
    input  logic [DEPTH_BITS-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]      i_wr_data,
    input  logic                  i_rd_en,
    input  logic [DEPTH_BITS-1:0] i_rd_addr,
    output logic [WIDTH-1:0]      o_rd_data
);

    logic [WIDTH-1:0] r_mem [2**DEPTH_BITS];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port; a read at the written address sees old data.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/cbd_exec.sv
// Execute stage: address decode, controller shifters, DMA sequencer and tick phase.
// Uses cbd_pkg for word types and codes; work RAM data arrives from the top level.
module cbd_exec (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  cbd_pkg::t_in_word  i_word,
    input  logic [7:0]         i_ram_data,
    output cbd_pkg::t_out_word o_result,
    output cbd_pkg::t_ram_wr   o_ram_wr,
    output logic [15:0]        o_fetch_next
);

    logic [7:0] r_pad [2];
    logic [7:0] r_page;
    logic [7:0] r_offset;
    logic [7:0] r_latch;
    logic       r_active;
    logic       r_align;
    logic [2:0] r_phase;

    logic [7:0] n_pad [2];
    logic [7:0] n_page;
    logic [7:0] n_offset;
    logic [7:0] n_latch;
    logic       n_active;
    logic       n_align;
    logic [2:0] n_phase;

    logic        is_fetch;
    logic [15:0] bus_addr;
    logic        hit_ram;
    logic        hit_ppu;
    logic        hit_pad;
    logic        hit_dma;
    logic        port;
    logic [7:0]  rd_byte;
    logic        do_read;

    // Bus address: the CPU address, or the DMA source on a fetch tick.
    assign is_fetch = (i_word.operation == cbd_pkg::OP_TICK) && r_active && !r_align
                      && (r_phase == cbd_pkg::PHASE_FETCH);
    assign bus_addr = is_fetch ? {r_page, r_offset} : i_word.address;
    assign hit_ram  = bus_addr <= cbd_pkg::RAM_TOP;
    assign hit_ppu  = bus_addr[15:13] == cbd_pkg::PPU_WINDOW;
    assign hit_pad  = bus_addr[15:1] == cbd_pkg::PAD_PAIR;
    assign hit_dma  = bus_addr == cbd_pkg::DMA_PAGE_ADR;
    assign port     = bus_addr[0];
    assign do_read  = (i_word.operation == cbd_pkg::OP_READ) || is_fetch;

    // Read decode in priority order: cartridge, RAM, PPU, controllers.
    always_comb begin
        if (i_word.cart_claims) begin
            rd_byte = i_word.cart_data;
        end else if (hit_ram) begin
            rd_byte = i_ram_data;
        end else if (hit_ppu) begin
            rd_byte = i_word.ppu_data;
        end else if (hit_pad) begin
            rd_byte = {7'd0, r_pad[port][7]};
        end else begin
            rd_byte = 8'd0;
        end
    end

    // Next state and result for the word in the stage.
    always_comb begin
        o_result = '0;
        o_ram_wr = '0;
        n_pad[0] = r_pad[0];
        n_pad[1] = r_pad[1];
        n_page   = r_page;
        n_offset = r_offset;
        n_latch  = r_latch;
        n_active = r_active;
        n_align  = r_align;
        n_phase  = r_phase;

        // Read side effects shared by CPU reads and DMA fetches.
        if (do_read && !i_word.cart_claims && !hit_ram) begin
            if (hit_ppu) begin
                o_result.ppu_access   = 1'b1;
                o_result.ppu_register = bus_addr[2:0];
                o_result.ppu_peek     = (i_word.operation == cbd_pkg::OP_READ)
                                        && i_word.read_only;
            end else if (hit_pad) begin
                n_pad[port] = {r_pad[port][6:0], 1'b0};
            end
        end

        case (i_word.operation)
            cbd_pkg::OP_READ: begin
                o_result.read_data = rd_byte;
            end
            cbd_pkg::OP_WRITE: begin
                if (!i_word.cart_claims) begin
                    if (hit_ram) begin
                        o_ram_wr.en   = i_advance;
                        o_ram_wr.addr = bus_addr & cbd_pkg::RAM_MIRROR;
                        o_ram_wr.data = i_word.write_data;
                    end else if (hit_ppu) begin
                        o_result.ppu_access   = 1'b1;
                        o_result.ppu_register = bus_addr[2:0];
                    end else if (hit_dma) begin
                        n_page   = i_word.write_data;
                        n_offset = 8'd0;
                        n_active = 1'b1;
                    end else if (hit_pad) begin
                        n_pad[port] = i_word.controller_buttons;
                    end
                end
            end
            cbd_pkg::OP_TICK: begin
                // CPU grant and DMA sequencing on the two active phases.
                if (r_phase == cbd_pkg::PHASE_FETCH || r_phase == cbd_pkg::PHASE_STORE) begin
                    if (!r_active) begin
                        o_result.cpu_step = 1'b1;
                    end else if (r_align) begin
                        if (r_phase == cbd_pkg::PHASE_STORE) begin
                            n_align = 1'b0;
                        end
                    end else if (r_phase == cbd_pkg::PHASE_FETCH) begin
                        n_latch = rd_byte;
                    end else begin
                        o_result.oam_write   = 1'b1;
                        o_result.oam_address = r_offset;
                        o_result.oam_data    = r_latch;
                        n_offset             = r_offset + 8'd1;
                        if (r_offset == 8'hFF) begin
                            n_active = 1'b0;
                            n_align  = 1'b1;
                        end
                    end
                end
                o_result.nmi_to_cpu = i_word.ppu_nmi;
                n_phase = (r_phase == cbd_pkg::PHASE_LAST) ? 3'd0 : r_phase + 3'd1;
            end
            default: begin
                // Unused code: no effect.
            end
        endcase

        o_result.dma_fetch_address = {n_page, n_offset};
    end

    assign o_fetch_next = i_advance ? {n_page, n_offset} : {r_page, r_offset};

    // Architectural state; changes only when the word leaves the stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pad[0] <= 8'd0;
            r_pad[1] <= 8'd0;
            r_page   <= 8'd0;
            r_offset <= 8'd0;
            r_latch  <= 8'd0;
            r_active <= 1'b0;
            r_align  <= 1'b1;
            r_phase  <= 3'd0;
        end else if (i_advance) begin
            r_pad[0] <= n_pad[0];
            r_pad[1] <= n_pad[1];
            r_page   <= n_page;
            r_offset <= n_offset;
            r_latch  <= n_latch;
            r_active <= n_active;
            r_align  <= n_align;
            r_phase  <= n_phase;
        end
    end

endmodule

FILE: rtl/core/console_cpu_bus_decoder_dma_core.sv
// Top level of the console CPU bus decoder with sprite DMA.
// Each input word is a CPU read, a CPU write or one system tick; each gives one result word.
// Both channels use valid/ready; a word moves when valid and ready are high at a clock edge.
// The input word is held in the input register and its result word in the result register;
// the receiver takes the result word from the result register.
// Throughput: one word per cycle while the receiver does not stall.
// The work RAM read for a word is issued as it is accepted, so the data is ready when the
// word sits in the input register; a RAM write from the word ahead is forwarded around
// the RAM's read-before-write port.
// When the receiver stalls, the result register holds its word and the input register
// fills; after that ready drops until the receiver takes a word.
// Reset (synchronous, active low) clears the controller shifters, DMA state and tick phase;
// the work RAM keeps its contents and must be written before it is read.
// Depends on cbd_pkg, cbd_ram and cbd_exec.
module console_cpu_bus_decoder_dma_core #(
    parameter int RAM_ADDRESS_BITS = 11
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  cbd_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output cbd_pkg::t_out_word o_out_word
);

    localparam logic [RAM_ADDRESS_BITS-1:0] IdxMask = RAM_ADDRESS_BITS'(cbd_pkg::RAM_MIRROR);

    logic                        r_in_valid;
    cbd_pkg::t_in_word           r_in;
    logic                        r_out_valid;
    cbd_pkg::t_out_word          r_out;
    logic                        r_byp_hit;
    logic [7:0]                  r_byp_data;

    logic                        accept_in;
    logic                        advance;
    cbd_pkg::t_out_word          result;
    cbd_pkg::t_ram_wr            ram_wr;
    logic [15:0]                 fetch_next;
    logic [15:0]                 rd_addr;
    logic [RAM_ADDRESS_BITS-1:0] rd_idx;
    logic [RAM_ADDRESS_BITS-1:0] wr_idx;
    logic [7:0]                  ram_q;
    logic [7:0]                  ram_data;

    // Handshake: the stage moves on when the result register is free or being emptied.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign accept_in  = i_in_valid && o_in_ready;

    // RAM read address for the incoming word: its own address, or the DMA source on a tick.
    assign rd_addr = (i_in_word.operation == cbd_pkg::OP_TICK) ? fetch_next : i_in_word.address;
    assign rd_idx  = rd_addr[RAM_ADDRESS_BITS-1:0] & IdxMask;
    assign wr_idx  = ram_wr.addr[RAM_ADDRESS_BITS-1:0] & IdxMask;

    cbd_ram #(
        .WIDTH      (8),
        .DEPTH_BITS (RAM_ADDRESS_BITS)
    ) u_work_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr.en),
        .i_wr_addr (wr_idx),
        .i_wr_data (ram_wr.data),
        .i_rd_en   (accept_in),
        .i_rd_addr (rd_idx),
        .o_rd_data (ram_q)
    );

    // Forwarded write data wins over the stale RAM read.
    assign ram_data = r_byp_hit ? r_byp_data : ram_q;

    cbd_exec u_exec (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (advance),
        .i_word       (r_in),
        .i_ram_data   (ram_data),
        .o_result     (result),
        .o_ram_wr     (ram_wr),
        .o_fetch_next (fetch_next)
    );

    // Input register, forwarding register and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_byp_hit   <= 1'b0;
        end else begin
            if (accept_in) begin
                r_in_valid <= 1'b1;
                r_byp_hit  <= ram_wr.en && (wr_idx == rd_idx);
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (accept_in) begin
            r_in       <= i_in_word;
            r_byp_data <= ram_wr.data;
        end
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

FILE: tb/testbench.sv
// Testbench for console_cpu_bus_decoder_dma_core: bus decode, controller ports and sprite DMA.
// Words are predicted in the testbench and checked in order under random idling and stalls.
// Depends on cbd_pkg and the core RTL.
`timescale 1ns / 100ps

module testbench;

    // Operation code that the block must ignore.
    localparam logic [1:0] OP_NONE = 2'd3;
    localparam int RAM_DEPTH = 2048;
    localparam int HOLD_CYCLES = 300;
    localparam int PRINT_LIMIT = 40;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    cbd_pkg::t_in_word  i_in_word = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    cbd_pkg::t_out_word o_out_word;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic hold_off = 1'b0;
    int error_count = 0;

    // Bus state as the testbench sees it.
    logic [7:0]         ram_image [RAM_DEPTH];
    bit                 ram_written [RAM_DEPTH];
    logic [10:0]        ram_filled [$];
    logic [7:0]         pad_bits [2];
    logic [7:0]         src_page;
    logic [7:0]         dma_index;
    logic [7:0]         dma_byte;
    logic               dma_busy;
    logic               dma_wait_align;
    logic [2:0]         phase;
    cbd_pkg::t_out_word res;
    cbd_pkg::t_out_word bus_results_due [$];

    console_cpu_bus_decoder_dma_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Read decode shared by CPU reads and DMA fetches; sets the PPU strobe fields of res.
    function automatic logic [7:0] decode_read(input logic [15:0] a, input logic peek,
                                               input cbd_pkg::t_in_word w);
        logic b;
        if (w.cart_claims) return w.cart_data;
        if (a <= cbd_pkg::RAM_TOP) return ram_image[a[10:0]];
        if (a[15:13] == cbd_pkg::PPU_WINDOW) begin
            res.ppu_access = 1'b1;
            res.ppu_register = a[2:0];
            res.ppu_peek = peek;
            return w.ppu_data;
        end
        if (a[15:1] == cbd_pkg::PAD_PAIR) begin
            b = pad_bits[a[0]][7];
            pad_bits[a[0]] = pad_bits[a[0]] << 1;
            return {7'd0, b};
        end
        return 8'h00;
    endfunction

    // Applies one accepted word to the bus state and returns the result word it gives.
    function automatic cbd_pkg::t_out_word predict_bus_result(input cbd_pkg::t_in_word w);
        res = '0;
        case (w.operation)
            cbd_pkg::OP_READ: begin
                res.read_data = decode_read(w.address, w.read_only, w);
            end
            cbd_pkg::OP_WRITE: begin
                if (!w.cart_claims) begin
                    if (w.address <= cbd_pkg::RAM_TOP) begin
                        ram_image[w.address[10:0]] = w.write_data;
                        if (!ram_written[w.address[10:0]]) begin
                            ram_written[w.address[10:0]] = 1'b1;
                            ram_filled.push_back(w.address[10:0]);
                        end
                    end else if (w.address[15:13] == cbd_pkg::PPU_WINDOW) begin
                        res.ppu_access = 1'b1;
                        res.ppu_register = w.address[2:0];
                    end else if (w.address == cbd_pkg::DMA_PAGE_ADR) begin
                        src_page = w.write_data;
                        dma_index = 8'h00;
                        dma_busy = 1'b1;
                    end else if (w.address[15:1] == cbd_pkg::PAD_PAIR) begin
                        pad_bits[w.address[0]] = w.controller_buttons;
                    end
                end
            end
            cbd_pkg::OP_TICK: begin
                if (phase == cbd_pkg::PHASE_FETCH || phase == cbd_pkg::PHASE_STORE) begin
                    if (!dma_busy) begin
                        res.cpu_step = 1'b1;
                    end else if (dma_wait_align) begin
                        if (phase == cbd_pkg::PHASE_STORE) dma_wait_align = 1'b0;
                    end else if (phase == cbd_pkg::PHASE_FETCH) begin
                        dma_byte = decode_read({src_page, dma_index}, 1'b0, w);
                    end else begin
                        res.oam_write = 1'b1;
                        res.oam_address = dma_index;
                        res.oam_data = dma_byte;
                        dma_index = dma_index + 8'd1;
                        if (dma_index == 8'h00) begin
                            dma_busy = 1'b0;
                            dma_wait_align = 1'b1;
                        end
                    end
                end
                res.nmi_to_cpu = w.ppu_nmi;
                phase = (phase == cbd_pkg::PHASE_LAST) ? cbd_pkg::PHASE_FETCH : phase + 3'd1;
            end
            default: begin
            end
        endcase
        res.dma_fetch_address = {src_page, dma_index};
        return res;
    endfunction

    // Keeps reads, CPU or DMA, away from RAM entries that were never written.
    function automatic cbd_pkg::t_in_word steer_off_blank_ram(input cbd_pkg::t_in_word w);
        cbd_pkg::t_in_word f;
        logic [1:0] mirror;
        f = w;
        if (f.operation == cbd_pkg::OP_READ && !f.cart_claims && f.address <= cbd_pkg::RAM_TOP
                && !ram_written[f.address[10:0]]) begin
            if (ram_filled.size() == 0) begin
                f.cart_claims = 1'b1;
            end else begin
                mirror = 2'($urandom_range(3));
                f.address = {3'b000, mirror,
                             ram_filled[$urandom_range(ram_filled.size() - 1)]};
            end
        end
        if (f.operation == cbd_pkg::OP_TICK && dma_busy && !dma_wait_align
                && phase == cbd_pkg::PHASE_FETCH
                && !f.cart_claims && {src_page, dma_index} <= cbd_pkg::RAM_TOP
                && !ram_written[{src_page[2:0], dma_index}]) begin
            f.cart_claims = 1'b1;
        end
        return f;
    endfunction

    function automatic cbd_pkg::t_in_word bus_word(input logic [1:0] op,
                                                   input logic [15:0] a,
                                                   input logic [7:0] d);
        cbd_pkg::t_in_word w;
        w = '0;
        w.operation = op;
        w.address = a;
        w.write_data = d;
        return w;
    endfunction

    // Random word, weighted toward the decoded regions.
    function automatic cbd_pkg::t_in_word random_word();
        cbd_pkg::t_in_word w;
        int pick;
        w.write_data = 8'($urandom);
        w.read_only = 1'($urandom);
        w.cart_claims = ($urandom_range(99) < 15);
        w.cart_data = 8'($urandom);
        w.ppu_data = 8'($urandom);
        w.controller_buttons = 8'($urandom);
        w.ppu_nmi = 1'($urandom);
        pick = $urandom_range(99);
        if (pick < 34) w.operation = cbd_pkg::OP_READ;
        else if (pick < 58) w.operation = cbd_pkg::OP_WRITE;
        else if (pick < 97) w.operation = cbd_pkg::OP_TICK;
        else w.operation = OP_NONE;
        pick = $urandom_range(99);
        if (pick < 40) w.address = {3'b000, 13'($urandom)};
        else if (pick < 60) w.address = {cbd_pkg::PPU_WINDOW, 13'($urandom)};
        else if (pick < 72) w.address = {cbd_pkg::PAD_PAIR, 1'($urandom)};
        else if (pick < 74) w.address = cbd_pkg::DMA_PAGE_ADR;
        else w.address = 16'($urandom);
        return w;
    endfunction

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= PRINT_LIMIT) $display("ERROR at %0t: %s", $time, msg);
    endtask

    task automatic compare_field(input string name, input logic [15:0] got,
                                 input logic [15:0] want);
        if (got !== want)
            report_error($sformatf("%s got %h, expected %h", name, got, want));
    endtask

    // Offers one word, holds it until accepted, then records its expected result.
    task automatic send_word(input cbd_pkg::t_in_word w);
        cbd_pkg::t_in_word legal;
        legal = steer_off_blank_ram(w);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word <= legal;
        do @(posedge i_clk); while (!o_in_ready);
        bus_results_due.push_back(predict_bus_result(legal));
    endtask

    // Stops offering words until every expected result has come back.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (bus_results_due.size() != 0);
    endtask

    // Result checking and receiver stalls.
    always @(posedge i_clk) begin : result_check
        cbd_pkg::t_out_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (bus_results_due.size() == 0) begin
                report_error("result word with nothing expected");
            end else begin
                want = bus_results_due.pop_front();
                compare_field("read_data", 16'(o_out_word.read_data), 16'(want.read_data));
                compare_field("ppu_access", 16'(o_out_word.ppu_access),
                              16'(want.ppu_access));
                compare_field("ppu_register", 16'(o_out_word.ppu_register),
                              16'(want.ppu_register));
                compare_field("ppu_peek", 16'(o_out_word.ppu_peek), 16'(want.ppu_peek));
                compare_field("cpu_step", 16'(o_out_word.cpu_step), 16'(want.cpu_step));
                compare_field("oam_write", 16'(o_out_word.oam_write), 16'(want.oam_write));
                compare_field("oam_address", 16'(o_out_word.oam_address),
                              16'(want.oam_address));
                compare_field("oam_data", 16'(o_out_word.oam_data), 16'(want.oam_data));
                compare_field("nmi_to_cpu", 16'(o_out_word.nmi_to_cpu),
                              16'(want.nmi_to_cpu));
                compare_field("dma_fetch_address", o_out_word.dma_fetch_address,
                              want.dma_fetch_address);
            end
        end
        i_out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    // RAM mirroring, cartridge priority, PPU window, unmapped space and the ignored opcode.
    task automatic test_decode_map();
        cbd_pkg::t_in_word w;
        send_word(bus_word(cbd_pkg::OP_WRITE, 16'h0000, 8'h00));
        send_word(bus_word(cbd_pkg::OP_WRITE, 16'h1FFF, 8'hFF));
        send_word(bus_word(cbd_pkg::OP_READ, 16'h0800, 8'h00));
        send_word(bus_word(cbd_pkg::OP_READ, 16'h07FF, 8'h00));
        w = bus_word(cbd_pkg::OP_WRITE, 16'h0000, 8'h5A);
        w.cart_claims = 1'b1;
        send_word(w);
        w = bus_word(cbd_pkg::OP_READ, 16'h1800, 8'h00);
        w.cart_claims = 1'b1;
        w.cart_data = 8'hA5;
        send_word(w);
        send_word(bus_word(cbd_pkg::OP_READ, 16'h1800, 8'h00));
        w = bus_word(cbd_pkg::OP_READ, 16'h2000, 8'h00);
        w.ppu_data = 8'hFF;
        send_word(w);
        w = bus_word(cbd_pkg::OP_READ, 16'h3FFF, 8'h00);
        w.read_only = 1'b1;
        w.ppu_data = 8'h3C;
        send_word(w);
        send_word(bus_word(cbd_pkg::OP_WRITE, 16'h2007, 8'h81));
        send_word(bus_word(cbd_pkg::OP_READ, cbd_pkg::DMA_PAGE_ADR, 8'h00));
        send_word(bus_word(cbd_pkg::OP_READ, 16'hFFFF, 8'h00));
        w = '1;
        w.operation = OP_NONE;
        send_word(w);
    endtask

    // Controller load, serial shift-out, and a peek that still shifts.
    task automatic test_controllers();
        cbd_pkg::t_in_word w;
        w = bus_word(cbd_pkg::OP_WRITE, 16'h4016, 8'h00);
        w.controller_buttons = 8'h81;
        send_word(w);
        w = bus_word(cbd_pkg::OP_WRITE, 16'h4017, 8'h00);
        w.controller_buttons = 8'h7F;
        send_word(w);
        send_word(bus_word(cbd_pkg::OP_READ, 16'h4016, 8'h00));
        w = bus_word(cbd_pkg::OP_READ, 16'h4016, 8'h00);
        w.read_only = 1'b1;
        send_word(w);
        send_word(bus_word(cbd_pkg::OP_READ, 16'h4017, 8'h00));
    endtask

    // DMA from the PPU page, then a restart into RAM while alignment is kept.
    task automatic test_dma_restart();
        cbd_pkg::t_in_word w;
        send_word(bus_word(cbd_pkg::OP_WRITE, cbd_pkg::DMA_PAGE_ADR, 8'h21));
        repeat (6) begin
            w = bus_word(cbd_pkg::OP_TICK, 16'h0000, 8'h00);
            w.ppu_nmi = 1'($urandom);
            w.ppu_data = 8'($urandom);
            send_word(w);
        end
        send_word(bus_word(cbd_pkg::OP_WRITE, cbd_pkg::DMA_PAGE_ADR, 8'h00));
        repeat (5) begin
            w = bus_word(cbd_pkg::OP_TICK, 16'h0000, 8'h00);
            w.ppu_nmi = 1'($urandom);
            send_word(w);
        end
    endtask

    // One whole 256-byte transfer from the controller page, with bus traffic mixed in.
    task automatic test_full_sprite_transfer();
        cbd_pkg::t_in_word w;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        w = bus_word(cbd_pkg::OP_WRITE, 16'h4016, 8'h00);
        w.controller_buttons = 8'($urandom);
        send_word(w);
        send_word(bus_word(cbd_pkg::OP_WRITE, cbd_pkg::DMA_PAGE_ADR, 8'h40));
        while (dma_busy) begin
            w = random_word();
            if ($urandom_range(15) != 0) w.operation = cbd_pkg::OP_TICK;
            else if (w.operation == cbd_pkg::OP_WRITE && w.address == cbd_pkg::DMA_PAGE_ADR)
                w.operation = cbd_pkg::OP_READ;
            send_word(w);
        end
        wait_drained();
    endtask

    task automatic test_random_traffic(input int count, input int send_pct,
                                       input int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        repeat (count) send_word(random_word());
        wait_drained();
    endtask

    // The receiver holds off for a long stretch so the block fills and stalls its input.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fork
            begin
                hold_off <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off <= 1'b0;
            end
        join_none
        repeat (40) send_word(random_word());
        wait_drained();
    endtask

    initial begin
        pad_bits[0] = 8'h00;
        pad_bits[1] = 8'h00;
        src_page = 8'h00;
        dma_index = 8'h00;
        dma_byte = 8'h00;
        dma_busy = 1'b0;
        dma_wait_align = 1'b1;
        phase = cbd_pkg::PHASE_FETCH;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_decode_map();
        test_controllers();
        test_dma_restart();
        wait_drained();

        test_random_traffic(50, 0, 0);
        test_random_traffic(50, 77, 0);
        test_random_traffic(50, 0, 77);
        test_random_traffic(50, 22, 22);
        test_full_sprite_transfer();
        test_backpressure();

        // Anything arriving now is unexpected.
        repeat (8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Run limit, well beyond the slowest passing run.
    initial begin
        #400_000;
        $display("FAIL");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/cbd_pkg.sv
rtl/core/cbd_ram.sv
rtl/core/cbd_exec.sv
rtl/core/console_cpu_bus_decoder_dma_core.sv
tb/testbench.sv
